// ----- rtl/tlif_pkg.sv -----
// Shared types and constants for the text line input filter.
package tlif_pkg;

    localparam int LINE_LIMIT = 512;
    localparam int POS_W      = $clog2(LINE_LIMIT + 1);
    localparam int LEN_W      = 10;
    localparam int LINE_W     = 16;
    localparam int CNT_W      = 32;
    localparam int CHAR_W     = 7;
    localparam int KIND_W     = 3;
    localparam int FUNC_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int OUT_DATA_W = 136;

    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_END   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_CHAR    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LINE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PARTIAL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TOOLONG = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EOF     = 3'd4;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NUL     = 3'd0;
    localparam logic [OP_W-1:0] OP_EMPTY   = 3'd1;
    localparam logic [OP_W-1:0] OP_CHAR    = 3'd2;
    localparam logic [OP_W-1:0] OP_NEWLINE = 3'd3;
    localparam logic [OP_W-1:0] OP_END     = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 7'd10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic              dirty;
        logic [CHAR_W-1:0] ch;
    } tlif_entry_t;

endpackage

// ----- rtl/text_line_input_filter_top.sv -----
// Top level of the text line input filter.
//
// Input channel s_*: one transfer per raw file byte (func 0), end of input
// (func 1) or clear statistics (func 2); func 3 is taken and ignored.
// Output channel m_*: zero or one result per input transfer, in order:
// a character, a line end, an incomplete last line, a too-long line, or
// end of file, each carrying the running line, character, NUL and dirty
// totals after that transfer.
// Throughput: one input transfer per cycle, sustained, while m_tready is
// high; the back end retires one queued operation per cycle unless m_* is stalled.
// Path: an input transfer is written into the four-entry queue, and the
// back end moves it from the queue head into its output register, which
// drives m_*.
// Stall: while m_tready is low the result is held and the queue absorbs up
// to four more transfers before s_tready drops.
// Reset: line position and all counters go to zero and the queue empties.
module text_line_input_filter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tlif_pkg::BYTE_W-1:0]     s_tdata,  // [7:0] data_byte
    input  logic [tlif_pkg::FUNC_W-1:0]     s_tuser,  // [1:0] func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [6:0] char_out, [16:7] line_length, [32:17] line_total,
    // [64:33] char_total, [96:65] null_total, [128:97] dirty_total, rest zero
    output logic [tlif_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [tlif_pkg::KIND_W-1:0]     m_tuser   // [2:0] kind
);

    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_head_valid;
    tlif_pkg::tlif_entry_t q_push_entry;
    tlif_pkg::tlif_entry_t q_head_entry;

    tlif_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_push_entry)
    );

    tlif_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry)
    );

    tlif_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// ----- rtl/tlif_front.sv -----
// Front end: accepts input transfers and classifies each byte into an operation.
module tlif_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tlif_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic [tlif_pkg::FUNC_W-1:0] s_tuser,   // [1:0] func
    input  logic                        q_full,
    output logic                        q_push,
    output tlif_pkg::tlif_entry_t       q_entry
);

    logic [tlif_pkg::CHAR_W-1:0] low7;
    logic                        known;

    assign low7     = s_tdata[tlif_pkg::CHAR_W-1:0];
    assign s_tready = !q_full;
    assign known    = (s_tuser == tlif_pkg::FUNC_DATA) || (s_tuser == tlif_pkg::FUNC_END)
                   || (s_tuser == tlif_pkg::FUNC_CLEAR);
    assign q_push   = s_tvalid && !q_full && known;

    always_comb
    begin
        q_entry.dirty = s_tdata[tlif_pkg::BYTE_W-1];
        q_entry.ch    = low7;
        case (s_tuser)
            tlif_pkg::FUNC_DATA:
            begin
                if (s_tdata == '0)
                begin
                    q_entry.op = tlif_pkg::OP_NUL;
                end
                else if (low7 == '0)
                begin
                    q_entry.op = tlif_pkg::OP_EMPTY;
                end
                else if (low7 == tlif_pkg::NEWLINE_CODE)
                begin
                    q_entry.op = tlif_pkg::OP_NEWLINE;
                end
                else
                begin
                    q_entry.op = tlif_pkg::OP_CHAR;
                end
            end
            tlif_pkg::FUNC_END:   q_entry.op = tlif_pkg::OP_END;
            tlif_pkg::FUNC_CLEAR: q_entry.op = tlif_pkg::OP_CLEAR;
            default:              q_entry.op = tlif_pkg::OP_CLEAR;
        endcase
    end

endmodule

// ----- rtl/tlif_queue.sv -----
// Short operation queue between the front end and the back end.
module tlif_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tlif_pkg::tlif_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output tlif_pkg::tlif_entry_t head_entry
);

    tlif_pkg::tlif_entry_t           mem_reg [tlif_pkg::QDEPTH];
    logic [tlif_pkg::QA_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [tlif_pkg::QA_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [tlif_pkg::QC_W-1:0]       cnt_reg, cnt_next;
    logic                            do_pop;

    assign full       = (cnt_reg == tlif_pkg::QC_W'(tlif_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + tlif_pkg::QC_W'(push) - tlif_pkg::QC_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/tlif_back.sv -----
// Back end: line position, saturating counters and the output register.
module tlif_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  tlif_pkg::tlif_entry_t         head_entry,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tlif_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [tlif_pkg::KIND_W-1:0]   m_tuser
);

    localparam int PAD_W = tlif_pkg::OUT_DATA_W - tlif_pkg::CHAR_W - tlif_pkg::LEN_W
                         - tlif_pkg::LINE_W - 3 * tlif_pkg::CNT_W;

    logic [tlif_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [tlif_pkg::LINE_W-1:0] line_reg, line_next;
    logic [tlif_pkg::CNT_W-1:0]  char_reg, char_next;
    logic [tlif_pkg::CNT_W-1:0]  null_reg, null_next;
    logic [tlif_pkg::CNT_W-1:0]  dirty_reg, dirty_next;

    logic                        out_valid_reg, out_valid_next;
    logic [tlif_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [tlif_pkg::CHAR_W-1:0] ch_reg, ch_next;
    logic [tlif_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [tlif_pkg::LINE_W-1:0] oline_reg;
    logic [tlif_pkg::CNT_W-1:0]  ochar_reg, onull_reg, odirty_reg;

    logic                        emit;
    logic                        at_limit;
    logic                        close;
    logic [tlif_pkg::POS_W:0]    close_len;
    logic [tlif_pkg::CNT_W:0]    char_sum;
    logic [tlif_pkg::CNT_W-1:0]  null_inc, dirty_inc;
    logic [tlif_pkg::LINE_W-1:0] line_inc;

    assign pop      = head_valid && (!out_valid_reg || m_tready);
    assign at_limit = (pos_reg >= tlif_pkg::POS_W'(tlif_pkg::LINE_LIMIT));
    assign null_inc  = (null_reg == '1) ? null_reg : null_reg + 1'b1;
    assign dirty_inc = (dirty_reg == '1) ? dirty_reg : dirty_reg + 1'b1;
    assign line_inc  = (line_reg == '1) ? line_reg : line_reg + 1'b1;
    assign char_sum  = {1'b0, char_reg} + (tlif_pkg::CNT_W + 1)'(close_len);

    always_comb
    begin
        pos_next   = pos_reg;
        line_next  = line_reg;
        char_next  = char_reg;
        null_next  = null_reg;
        dirty_next = dirty_reg;
        emit       = 1'b0;
        close      = 1'b0;
        kind_next  = tlif_pkg::KIND_CHAR;
        ch_next    = '0;
        len_next   = '0;
        close_len  = {1'b0, pos_reg} + 1'b1;
        case (head_entry.op)
            tlif_pkg::OP_NUL, tlif_pkg::OP_EMPTY, tlif_pkg::OP_CHAR, tlif_pkg::OP_NEWLINE:
            begin
                if (at_limit)
                begin
                    pos_next  = '0;
                    emit      = 1'b1;
                    kind_next = tlif_pkg::KIND_TOOLONG;
                end
                else if (head_entry.op == tlif_pkg::OP_NUL)
                begin
                    null_next = null_inc;
                end
                else
                begin
                    if (head_entry.dirty)
                    begin
                        dirty_next = dirty_inc;
                    end
                    if (head_entry.op == tlif_pkg::OP_CHAR)
                    begin
                        pos_next  = pos_reg + 1'b1;
                        emit      = 1'b1;
                        kind_next = tlif_pkg::KIND_CHAR;
                        ch_next   = head_entry.ch;
                    end
                    else if (head_entry.op == tlif_pkg::OP_NEWLINE)
                    begin
                        close     = 1'b1;
                        emit      = 1'b1;
                        kind_next = tlif_pkg::KIND_LINE;
                        ch_next   = head_entry.ch;
                    end
                end
            end
            tlif_pkg::OP_END:
            begin
                close_len = {1'b0, pos_reg};
                emit      = 1'b1;
                if (pos_reg != '0)
                begin
                    close     = 1'b1;
                    kind_next = tlif_pkg::KIND_PARTIAL;
                end
                else
                begin
                    kind_next = tlif_pkg::KIND_EOF;
                end
            end
            tlif_pkg::OP_CLEAR:
            begin
                line_next  = '0;
                char_next  = '0;
                null_next  = '0;
                dirty_next = '0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        if (close)
        begin
            pos_next  = '0;
            line_next = line_inc;
            char_next = char_sum[tlif_pkg::CNT_W] ? '1 : char_sum[tlif_pkg::CNT_W-1:0];
            len_next  = tlif_pkg::LEN_W'(close_len);
        end
        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            line_reg      <= '0;
            char_reg      <= '0;
            null_reg      <= '0;
            dirty_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                pos_reg   <= pos_next;
                line_reg  <= line_next;
                char_reg  <= char_next;
                null_reg  <= null_next;
                dirty_reg <= dirty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            kind_reg   <= kind_next;
            ch_reg     <= ch_next;
            len_reg    <= len_next;
            oline_reg  <= line_next;
            ochar_reg  <= char_next;
            onull_reg  <= null_next;
            odirty_reg <= dirty_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {PAD_W'(0), odirty_reg, onull_reg, ochar_reg, oline_reg, len_reg, ch_reg};

endmodule

// ----- rtl/tlif_checker.sv -----
// Port-level checker for the text line input filter, bound to the top level.
module tlif_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tlif_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [tlif_pkg::KIND_W-1:0]     m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= tlif_pkg::KIND_EOF)
        else $error("result kind out of range");

    a_char_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == tlif_pkg::KIND_CHAR |-> m_tdata[16:7] == '0
            && m_tdata[6:0] != '0)
        else $error("character result with length or empty character");

    a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == tlif_pkg::KIND_EOF || m_tuser == tlif_pkg::KIND_TOOLONG)
            |-> m_tdata[16:0] == '0)
        else $error("status result carries character or length");

endmodule

bind text_line_input_filter_top tlif_checker u_tlif_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/tlif_line_checker.sv -----
// Checker for the text line input filter: predicts each result and compares the output stream.
module tlif_line_checker
    import tlif_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,
    input  logic [FUNC_W-1:0]     s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic [KIND_W-1:0]     m_tuser,
    output int                    mismatches,
    output int                    pending,
    output int                    checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_LSB   = CHAR_W;
    localparam int LINES_LSB = LEN_LSB + LEN_W;
    localparam int CHARS_LSB = LINES_LSB + LINE_W;
    localparam int NULLS_LSB = CHARS_LSB + CNT_W;
    localparam int DIRTY_LSB = NULLS_LSB + CNT_W;
    localparam int PRINT_MAX = 30;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic [LINE_W-1:0] lines;
        logic [CNT_W-1:0]  chars;
        logic [CNT_W-1:0]  nulls;
        logic [CNT_W-1:0]  dirties;
    } line_result_t;

    line_result_t      results_due[$];
    logic [POS_W-1:0]  line_fill;
    logic [LINE_W-1:0] lines_done;
    logic [CNT_W-1:0]  chars_done;
    logic [CNT_W-1:0]  nulls_seen;
    logic [CNT_W-1:0]  dirty_seen;
    int                mismatch_count;
    int                checked_count;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        if (mismatch_count < PRINT_MAX)
            $display("checker: %0t ns %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_result(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                                input logic [LEN_W-1:0] len);
        line_result_t r;
        r.kind    = kind;
        r.ch      = ch;
        r.len     = len;
        r.lines   = lines_done;
        r.chars   = chars_done;
        r.nulls   = nulls_seen;
        r.dirties = dirty_seen;
        results_due.push_back(r);
    endtask

    task automatic close_line();
        logic [CNT_W:0] sum;
        sum = {1'b0, chars_done} + line_fill;
        if (lines_done != '1)
            lines_done++;
        chars_done = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
    endtask

    task automatic predict_transfer(input logic [FUNC_W-1:0] func, input logic [BYTE_W-1:0] b);
        logic [CHAR_W-1:0] c;
        logic [LEN_W-1:0]  len;
        c = b[CHAR_W-1:0];
        case (func)
            FUNC_DATA:
            begin
                if (line_fill >= LINE_LIMIT)
                begin
                    line_fill = '0;
                    queue_result(KIND_TOOLONG, '0, '0);
                end
                else if (b == '0)
                    nulls_seen = sat_inc(nulls_seen);
                else
                begin
                    if (b[BYTE_W-1])
                        dirty_seen = sat_inc(dirty_seen);
                    if (c != '0)
                    begin
                        line_fill++;
                        if (c == NEWLINE_CODE)
                        begin
                            len = line_fill[LEN_W-1:0];
                            close_line();
                            line_fill = '0;
                            queue_result(KIND_LINE, c, len);
                        end
                        else
                            queue_result(KIND_CHAR, c, '0);
                    end
                end
            end
            FUNC_END:
            begin
                if (line_fill != '0)
                begin
                    len = line_fill[LEN_W-1:0];
                    close_line();
                    line_fill = '0;
                    queue_result(KIND_PARTIAL, '0, len);
                end
                else
                    queue_result(KIND_EOF, '0, '0);
            end
            FUNC_CLEAR:
            begin
                lines_done = '0;
                chars_done = '0;
                nulls_seen = '0;
                dirty_seen = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_result();
        line_result_t want;
        if (results_due.size() == 0)
            report_mismatch("result with none expected, kind", m_tuser, '0);
        else
        begin
            want = results_due.pop_front();
            checked_count++;
            if (m_tuser != want.kind)
                report_mismatch("kind", m_tuser, want.kind);
            if (m_tdata[CHAR_W-1:0] != want.ch)
                report_mismatch("char_out", m_tdata[CHAR_W-1:0], want.ch);
            if (m_tdata[LEN_LSB +: LEN_W] != want.len)
                report_mismatch("line_length", m_tdata[LEN_LSB +: LEN_W], want.len);
            if (m_tdata[LINES_LSB +: LINE_W] != want.lines)
                report_mismatch("line_total", m_tdata[LINES_LSB +: LINE_W], want.lines);
            if (m_tdata[CHARS_LSB +: CNT_W] != want.chars)
                report_mismatch("char_total", m_tdata[CHARS_LSB +: CNT_W], want.chars);
            if (m_tdata[NULLS_LSB +: CNT_W] != want.nulls)
                report_mismatch("null_total", m_tdata[NULLS_LSB +: CNT_W], want.nulls);
            if (m_tdata[DIRTY_LSB +: CNT_W] != want.dirties)
                report_mismatch("dirty_total", m_tdata[DIRTY_LSB +: CNT_W], want.dirties);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_fill      = '0;
            lines_done     = '0;
            chars_done     = '0;
            nulls_seen     = '0;
            dirty_seen     = '0;
            mismatch_count = 0;
            checked_count  = 0;
            results_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                predict_transfer(s_tuser, s_tdata);
        end
        mismatches <= mismatch_count;
        pending    <= results_due.size();
        checked    <= checked_count;
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the text line input filter testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                          HALF_PERIOD = 6;
    localparam int                          STALL_LIMIT = 2000;
    localparam int                          PHASE_ITEMS = 540;
    localparam logic [tlif_pkg::FUNC_W-1:0] FUNC_SPARE  = 2'd3;
    localparam logic [tlif_pkg::BYTE_W-1:0] LF_BYTE     = 8'h0A;
    localparam logic [tlif_pkg::BYTE_W-1:0] DIRTY_LF    = 8'h8A;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [tlif_pkg::BYTE_W-1:0]     s_tdata;
    logic [tlif_pkg::FUNC_W-1:0]     s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [tlif_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [tlif_pkg::KIND_W-1:0]     m_tuser;

    int mismatches;
    int pending;
    int checked;
    int source_idle_pct = 29;
    int sink_idle_pct   = 45;
    int items_sent      = 0;
    int line_fill       = 0;
    int limit_lines     = 0;
    int quiet_cycles    = 0;

    text_line_input_filter_top uut (.*);

    tlif_line_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [tlif_pkg::BYTE_W-1:0] rand_byte(input int lo, input int hi);
        return tlif_pkg::BYTE_W'($urandom_range(lo, hi));
    endfunction

    function automatic logic [tlif_pkg::BYTE_W-1:0] text_byte();
        int                          pick;
        logic [tlif_pkg::BYTE_W-1:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            b = rand_byte(8'h20, 8'h7E);
        else if (pick < 80)
            b = 8'h80 | rand_byte(1, 8'h7F);
        else if (pick < 88)
            b = 8'h00;
        else if (pick < 92)
            b = 8'h80;
        else
            b = rand_byte(0, 255);
        if (b[tlif_pkg::CHAR_W-1:0] == tlif_pkg::NEWLINE_CODE)
            b = 8'h2E;
        return b;
    endfunction

    task automatic send_item(input logic [tlif_pkg::FUNC_W-1:0] func,
                             input logic [tlif_pkg::BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < source_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (func == tlif_pkg::FUNC_DATA)
        begin
            if (line_fill >= tlif_pkg::LINE_LIMIT)
                line_fill = 0;
            else if (b[tlif_pkg::CHAR_W-1:0] != '0)
                line_fill = (b[tlif_pkg::CHAR_W-1:0] == tlif_pkg::NEWLINE_CODE) ? 0
                                                                              : line_fill + 1;
        end
        else if (func == tlif_pkg::FUNC_END)
            line_fill = 0;
    endtask

    // hold off new transfers until every queued result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic short_line(input bit close_with_end);
        int n;
        n = $urandom_range(0, 30);
        repeat (n)
            send_item(tlif_pkg::FUNC_DATA, text_byte());
        if (close_with_end)
            send_item(tlif_pkg::FUNC_END, rand_byte(0, 255));
        else
            send_item(tlif_pkg::FUNC_DATA, $urandom_range(0, 1) ? LF_BYTE : DIRTY_LF);
    endtask

    // variant 0: newline lands exactly at the limit; 1: byte past a full line;
    // 2: end of input with a full line held
    task automatic run_phase(input int budget, input int variant);
        int first;
        int pick;
        int n;
        int target;
        bit long_done;
        first     = items_sent;
        long_done = 1'b0;
        while (items_sent - first < budget)
        begin
            if (!long_done && items_sent - first >= budget / 10)
            begin
                send_item(tlif_pkg::FUNC_END, rand_byte(0, 255));
                target = (variant == 0) ? tlif_pkg::LINE_LIMIT - 1 : tlif_pkg::LINE_LIMIT;
                while (line_fill < target)
                    send_item(tlif_pkg::FUNC_DATA, text_byte());
                case (variant)
                    0: send_item(tlif_pkg::FUNC_DATA, LF_BYTE);
                    1: send_item(tlif_pkg::FUNC_DATA, rand_byte(0, 255));
                    default: send_item(tlif_pkg::FUNC_END, rand_byte(0, 255));
                endcase
                limit_lines++;
                long_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                short_line(1'b0);
            else if (pick < 80)
                short_line(1'b1);
            else if (pick < 86)
                send_item(tlif_pkg::FUNC_CLEAR, rand_byte(0, 255));
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_item(tlif_pkg::FUNC_W'($urandom_range(0, 3)), rand_byte(0, 255));
            end
        end
    endtask

    initial
    begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= tlif_pkg::FUNC_DATA;
        rst_n    <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(tlif_pkg::FUNC_END, 8'h00);
        send_item(tlif_pkg::FUNC_DATA, 8'h41);
        send_item(tlif_pkg::FUNC_DATA, 8'h00);
        send_item(tlif_pkg::FUNC_DATA, 8'h80);
        send_item(tlif_pkg::FUNC_DATA, 8'hFF);
        send_item(tlif_pkg::FUNC_DATA, 8'h01);
        send_item(tlif_pkg::FUNC_DATA, 8'h7F);
        send_item(tlif_pkg::FUNC_DATA, LF_BYTE);
        send_item(tlif_pkg::FUNC_DATA, 8'hC1);
        send_item(tlif_pkg::FUNC_DATA, DIRTY_LF);
        send_item(tlif_pkg::FUNC_DATA, 8'h78);
        send_item(tlif_pkg::FUNC_CLEAR, 8'h00);
        send_item(tlif_pkg::FUNC_DATA, LF_BYTE);
        send_item(FUNC_SPARE, 8'h55);
        send_item(tlif_pkg::FUNC_DATA, 8'h2A);
        send_item(tlif_pkg::FUNC_END, 8'hAA);
        send_item(tlif_pkg::FUNC_END, 8'hFF);
        send_item(tlif_pkg::FUNC_CLEAR, 8'hFF);
        send_item(FUNC_SPARE, 8'hFF);
        drain();

        run_phase(PHASE_ITEMS, 0);
        drain();
        source_idle_pct = 45;
        sink_idle_pct  <= 29;
        run_phase(PHASE_ITEMS, 1);
        drain();
        source_idle_pct = 0;
        sink_idle_pct  <= 0;
        run_phase(PHASE_ITEMS, 2);
        drain();
        repeat (8) @(posedge clk);

        $display("testbench: %0d input transfers sent, %0d results compared", items_sent,
                 checked);
        $display("testbench: %0d lines driven to the %0d-character limit, three stall mixes",
                 limit_lines, tlif_pkg::LINE_LIMIT);
        if (mismatches == 0 && pending == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- text_line_input_filter_top.f -----
rtl/tlif_pkg.sv
rtl/tlif_front.sv
rtl/tlif_queue.sv
rtl/tlif_back.sv
rtl/text_line_input_filter_top.sv
rtl/tlif_checker.sv
tb/sv/tlif_line_checker.sv
tb/sv/testbench.sv
